### hw/rtl/cbm_pkg.sv
// cbm_pkg: shared types and constants for the cartridge bank mapper with RTC.
// Used by cbm_decode, cbm_regs and cartridge_bank_mapper_with_rtc.
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int ROM_BANK_BITS = 7;
  localparam int RAM_BANK_BITS = 2;
  localparam int ADDR_BITS     = 21;
  localparam int RTC_COUNT     = 5;
  localparam int RTC_SEL_BITS  = 3;

  localparam logic       MODE_READ  = 1'b0;
  localparam logic       MODE_WRITE = 1'b1;

  localparam logic [7:0] ENABLE_ON  = 8'h0A;
  localparam logic [7:0] ENABLE_OFF = 8'h00;
  localparam logic [7:0] RAM_BANK_MAX = 8'h03;
  localparam logic [7:0] RTC_SEL_FIRST = 8'h08;
  localparam logic [7:0] RTC_SEL_LAST  = 8'h0C;

  // 8 KiB regions of the cartridge bus, keyed by address bits 15:13
  localparam logic [2:0] RGN_ENABLE   = 3'd0;
  localparam logic [2:0] RGN_ROM_BANK = 3'd1;
  localparam logic [2:0] RGN_RAM_BANK = 3'd2;
  localparam logic [2:0] RGN_LATCH    = 3'd3;
  localparam logic [2:0] RGN_EXT_RAM  = 3'd5;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_ROM_READ  = 3'd1,
    ST_RAM_READ  = 3'd2,
    ST_RAM_WRITE = 3'd3,
    ST_RTC_READ  = 3'd4,
    ST_RTC_WRITE = 3'd5,
    ST_BLOCKED   = 3'd6,
    ST_FAULT     = 3'd7
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    status_t               status;
    logic [ADDR_BITS-1:0]  mapped_address;
    logic [7:0]            rtc_read_data;
  } out_item_t;

  // Mapper state as seen by the decoder
  typedef struct packed {
    logic [ROM_BANK_BITS-1:0] rom_bank;
    logic [RAM_BANK_BITS-1:0] ram_bank;
    logic                     ram_rtc_enable;
    logic                     rtc_is_mapped;
    logic [7:0]               rtc_byte;
  } cbm_state_t;

  // State updates requested by one access
  typedef struct packed {
    logic                     enable_set;
    logic                     enable_clr;
    logic                     rom_we;
    logic [ROM_BANK_BITS-1:0] rom_val;
    logic                     ram_we;
    logic [RAM_BANK_BITS-1:0] ram_val;
    logic                     rtc_map;
    logic                     sel_we;
    logic [RTC_SEL_BITS-1:0]  sel_val;
    logic                     rtc_we;
    logic [7:0]               rtc_data;
  } cbm_upd_t;

endpackage

### hw/rtl/cbm_decode.sv
// cbm_decode: combinational decode of one bus request against the mapper state.
// Produces the result item and the state update. Depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_decode
  import cbm_pkg::*;
(
  input  in_item_t   item,
  input  cbm_state_t st,
  output out_item_t  res,
  output cbm_upd_t   upd
);

  logic [2:0] region;
  logic [7:0] data;
  logic [7:0] rom_data;
  logic       ext_ram;

  assign region  = item.bus_address[15:13];
  assign data    = item.write_data;
  assign ext_ram = (region == RGN_EXT_RAM);
  // bank value 0 becomes 1 before masking
  assign rom_data = (data == 8'h00) ? 8'h01 : data;

  always_comb begin
    res.status         = ST_IGNORED;
    res.mapped_address = '0;
    res.rtc_read_data  = '0;

    upd.enable_set = 1'b0;
    upd.enable_clr = 1'b0;
    upd.rom_we     = 1'b0;
    upd.rom_val    = rom_data[ROM_BANK_BITS-1:0];
    upd.ram_we     = 1'b0;
    upd.ram_val    = data[RAM_BANK_BITS-1:0];
    upd.rtc_map    = 1'b0;
    upd.sel_we     = 1'b0;
    upd.sel_val    = data[RTC_SEL_BITS-1:0];
    upd.rtc_we     = 1'b0;
    upd.rtc_data   = data;

    if (item.mode == MODE_READ) begin
      if (!item.bus_address[15]) begin
        res.status = ST_ROM_READ;
        if (!item.bus_address[14]) begin
          res.mapped_address = ADDR_BITS'(item.bus_address[13:0]);
        end else begin
          res.mapped_address = ADDR_BITS'({st.rom_bank, item.bus_address[13:0]});
        end
      end else if (ext_ram) begin
        if (!st.rtc_is_mapped) begin
          res.status         = ST_RAM_READ;
          res.mapped_address = ADDR_BITS'({st.ram_bank, item.bus_address[12:0]});
        end else begin
          res.status        = ST_RTC_READ;
          res.rtc_read_data = st.rtc_byte;
        end
      end else begin
        res.status = ST_FAULT;
      end
    end else begin
      case (region)
        RGN_ENABLE: begin
          upd.enable_set = (data == ENABLE_ON);
          upd.enable_clr = (data == ENABLE_OFF);
        end
        RGN_ROM_BANK: begin
          upd.rom_we = 1'b1;
        end
        RGN_RAM_BANK: begin
          if (data <= RAM_BANK_MAX) begin
            upd.ram_we = 1'b1;
          end else begin
            upd.rtc_map = 1'b1;
            upd.sel_we  = (data >= RTC_SEL_FIRST) && (data <= RTC_SEL_LAST);
          end
        end
        RGN_EXT_RAM: begin
          if (!st.ram_rtc_enable) begin
            res.status = ST_BLOCKED;
          end else if (!st.rtc_is_mapped) begin
            res.status         = ST_RAM_WRITE;
            res.mapped_address = ADDR_BITS'({st.ram_bank, item.bus_address[12:0]});
          end else begin
            res.status = ST_RTC_WRITE;
            upd.rtc_we = 1'b1;
          end
        end
        // clock latch and unmapped areas: drop the write
        default: begin
          res.status = ST_IGNORED;
        end
      endcase
    end
  end

endmodule

### hw/rtl/cbm_regs.sv
// cbm_regs: bank, enable, mapping, RTC select and RTC byte registers.
// Applies one update per accepted request. Depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_regs
  import cbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       upd_en,
  input  cbm_upd_t   upd,
  output cbm_state_t st
);

  logic [ROM_BANK_BITS-1:0] rom_bank_r;
  logic [RAM_BANK_BITS-1:0] ram_bank_r;
  logic                     enable_r;
  logic                     rtc_mapped_r;
  logic [RTC_SEL_BITS-1:0]  rtc_sel_r;
  logic [7:0]               rtc_bytes_r [RTC_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r   <= ROM_BANK_BITS'(1);
      ram_bank_r   <= '0;
      enable_r     <= 1'b0;
      rtc_mapped_r <= 1'b0;
      rtc_sel_r    <= '0;
      for (int i = 0; i < RTC_COUNT; i++) begin
        rtc_bytes_r[i] <= '0;
      end
    end else if (upd_en) begin
      if (upd.enable_set) begin
        enable_r <= 1'b1;
      end else if (upd.enable_clr) begin
        enable_r <= 1'b0;
      end
      if (upd.rom_we) begin
        rom_bank_r <= upd.rom_val;
      end
      if (upd.ram_we) begin
        ram_bank_r   <= upd.ram_val;
        rtc_mapped_r <= 1'b0;
      end else if (upd.rtc_map) begin
        rtc_mapped_r <= 1'b1;
      end
      if (upd.sel_we) begin
        rtc_sel_r <= upd.sel_val;
      end
      if (upd.rtc_we && (rtc_sel_r < RTC_SEL_BITS'(RTC_COUNT))) begin
        rtc_bytes_r[rtc_sel_r] <= upd.rtc_data;
      end
    end
  end

  always_comb begin
    st.rom_bank       = rom_bank_r;
    st.ram_bank       = ram_bank_r;
    st.ram_rtc_enable = enable_r;
    st.rtc_is_mapped  = rtc_mapped_r;
    st.rtc_byte       = (rtc_sel_r < RTC_SEL_BITS'(RTC_COUNT)) ? rtc_bytes_r[rtc_sel_r]
                                                               : 8'h00;
  end

endmodule

### hw/rtl/cartridge_bank_mapper_with_rtc.sv
// Cartridge bank mapper with RTC registers: takes one bus request per cycle
// while in_stall is low (read or write, 16-bit CPU address, data byte) and
// returns one result with a status code, the physical ROM/RAM byte address and
// the RTC byte on RTC reads. A request is registered, decoded against the
// mapper state in the next cycle and its result lands in the output register;
// throughput is one request per cycle while out_stall is low. Register writes
// take effect for the request that follows. Clock latch writes at 6000-7FFF
// are dropped. Depends on cbm_pkg, cbm_decode and cbm_regs.
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_rtc
  import cbm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;

  logic       advance;
  logic       in_fire;
  cbm_state_t st;
  cbm_upd_t   upd;
  out_item_t  res;

  // advance the request when the output register is free or being drained
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  cbm_decode u_decode (
    .item (s1_item_r),
    .st   (st),
    .res  (res),
    .upd  (upd)
  );

  cbm_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (advance),
    .upd    (upd),
    .st     (st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !(out_item.status == ST_ROM_READ || out_item.status == ST_RAM_READ ||
                   out_item.status == ST_RAM_WRITE)
    |-> out_item.mapped_address == '0)
    else $error("mapped address set on a non-memory result");

  a_rtc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_RTC_READ) |-> out_item.rtc_read_data == 8'h00)
    else $error("RTC data set on a non-RTC-read result");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with a free pipeline");

  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced request did not reach the output register");

endmodule
